FILE: hdl/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg: shared types and constants for the rational sum accumulator
// Widths, status codes, sequencer and divider states, the divider handshake
// structs and small helpers for sign extension, magnitude and range checks.
// ----------------------------------------------------------------------------
package rsa_pkg;

  // Width of the stored sum; inputs are taken from their low bits
  localparam int unsigned VALUE_WIDTH = 32;
  // Port field width and width of the cross products
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned WORD_W      = 2 * FIELD_W;
  // One quotient bit per divider cycle
  localparam int unsigned DIV_STEPS   = WORD_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int unsigned EXT_SHIFT   = FIELD_W - VALUE_WIDTH;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_GCD_ZERO = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_GCD,
    S_REM,
    S_DIVN,
    S_DIVD,
    S_OUT
  } seq_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX
  } div_state_e;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;

  // Sign-extend the low VALUE_WIDTH bits of a port field
  function automatic logic signed [FIELD_W-1:0] sext_value(input logic [FIELD_W-1:0] x);
    logic signed [FIELD_W-1:0] t;
    t = $signed(x << EXT_SHIFT);
    return t >>> EXT_SHIFT;
  endfunction

  // Unsigned magnitude of a two's complement word (minimum value maps to 2^63)
  function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (WORD_W'(0) - v) : v;
  endfunction

  // True when the word lies in the signed VALUE_WIDTH range
  function automatic logic fits_value(input logic [WORD_W-1:0] v);
    return (&v[WORD_W-1:VALUE_WIDTH-1]) | ~(|v[WORD_W-1:VALUE_WIDTH-1]);
  endfunction

endpackage

FILE: hdl/rsa_div.sv
// ----------------------------------------------------------------------------
// rsa_div: iterative signed divider with truncating quotient and remainder
// Restoring division on magnitudes, one quotient bit per cycle, then a sign
// fix state (DIV_FIX) that applies the signs. Remainder follows the dividend's sign.
// ----------------------------------------------------------------------------
module rsa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsa_pkg::div_req_t req_i,
  output rsa_pkg::div_rsp_t rsp_o
);
  import rsa_pkg::*;

  div_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [WORD_W-1:0]    rem_q, rem_d;
  logic [WORD_W-1:0]    quo_q, quo_d;
  logic [WORD_W-1:0]    mag_b_q, mag_b_d;
  logic                 qneg_q, qneg_d;
  logic                 rneg_q, rneg_d;

  logic [WORD_W:0]      shifted;
  logic [WORD_W+1:0]    diff;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_q, quo_q[WORD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, mag_b_q};

  // Sequence the load, bit steps and sign fix
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    mag_b_d = mag_b_q;
    qneg_d  = qneg_q;
    rneg_d  = rneg_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          quo_d   = magnitude(req_i.dividend);
          mag_b_d = magnitude(req_i.divisor);
          rem_d   = '0;
          qneg_d  = req_i.dividend[WORD_W-1] ^ req_i.divisor[WORD_W-1];
          rneg_d  = req_i.dividend[WORD_W-1];
          cnt_d   = '0;
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (!diff[WORD_W+1]) begin
          rem_d = diff[WORD_W-1:0];
          quo_d = {quo_q[WORD_W-2:0], 1'b1};
        end else begin
          rem_d = shifted[WORD_W-1:0];
          quo_d = {quo_q[WORD_W-2:0], 1'b0};
        end
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = DIV_FIX;
        end else begin
          cnt_d = cnt_q + DIV_CNT_W'(1);
        end
      end
      DIV_FIX: begin
        quo_d   = qneg_q ? (WORD_W'(0) - quo_q) : quo_q;
        rem_d   = rneg_q ? (WORD_W'(0) - rem_q) : rem_q;
        done_d  = 1'b1;
        state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    mag_b_q <= mag_b_d;
    qneg_q  <= qneg_d;
    rneg_q  <= rneg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: hdl/rational_sum_accumulator.sv
// ----------------------------------------------------------------------------
// rational_sum_accumulator: running fraction sum with gcd reduction
// Adds each input fraction to the stored sum by cross-multiplication into
// 64-bit words, reduces the pair by Euclid's algorithm and keeps the result
// when it fits the stored width.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | sink      | in_valid_i / in_stall_o | first_item, numerator, denom.
//   out     | source    | out_valid_o/out_stall_i | sum num., sum denom., status
//
// One item at a time: multiply and add in states S_MUL0 to S_MUL3 on one
// shared 32x32 multiplier, then a divider run for each Euclid remainder
// step, a final zero test and a divider run for each of the two final
// quotients, all on one bit-serial 64-bit divider.
// The input is stalled from acceptance until the result transfer completes.
// Reset sets the sum to 0/1; the result holds while out_stall_i is high.
// ----------------------------------------------------------------------------
module rational_sum_accumulator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        first_item_i,
  input  logic signed [rsa_pkg::FIELD_W-1:0] in_numerator_i,
  input  logic signed [rsa_pkg::FIELD_W-1:0] in_denominator_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [rsa_pkg::FIELD_W-1:0] sum_numerator_o,
  output logic signed [rsa_pkg::FIELD_W-1:0] sum_denominator_o,
  output logic [1:0]                  status_o
);
  import rsa_pkg::*;

  seq_state_e                     state_q, state_d;
  status_e                        status_q, status_d;
  logic signed [VALUE_WIDTH-1:0]  acc_num_q, acc_num_d;
  logic signed [VALUE_WIDTH-1:0]  acc_den_q, acc_den_d;
  logic signed [FIELD_W-1:0]      n2_q, n2_d;
  logic signed [FIELD_W-1:0]      d2_q, d2_d;
  logic [WORD_W-1:0]              prod_q, prod_d;
  logic [WORD_W-1:0]              num_q, num_d;
  logic [WORD_W-1:0]              den_q, den_d;
  logic [WORD_W-1:0]              a_q, a_d;
  logic [WORD_W-1:0]              b_q, b_d;
  logic [WORD_W-1:0]              rn_q, rn_d;

  logic signed [FIELD_W-1:0]      mul_a;
  logic signed [FIELD_W-1:0]      mul_b;
  logic signed [WORD_W-1:0]       mul_p;

  div_req_t                       div_req;
  div_rsp_t                       div_rsp;

  // Shared divider for remainders and final quotients
  rsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Select operands for the shared multiplier
  always_comb begin
    unique case (state_q)
      S_MUL0: begin
        mul_a = FIELD_W'(acc_num_q);
        mul_b = d2_q;
      end
      S_MUL1: begin
        mul_a = n2_q;
        mul_b = FIELD_W'(acc_den_q);
      end
      default: begin
        mul_a = FIELD_W'(acc_den_q);
        mul_b = d2_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sequence multiply, Euclid loop, reduction and result transfer
  always_comb begin
    state_d          = state_q;
    status_d         = status_q;
    acc_num_d        = acc_num_q;
    acc_den_d        = acc_den_q;
    n2_d             = n2_q;
    d2_d             = d2_q;
    prod_d           = prod_q;
    num_d            = num_q;
    den_d            = den_q;
    a_d              = a_q;
    b_d              = b_q;
    rn_d             = rn_q;
    div_req.start    = 1'b0;
    div_req.dividend = a_q;
    div_req.divisor  = b_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          n2_d = sext_value(in_numerator_i);
          d2_d = sext_value(in_denominator_i);
          if (first_item_i) begin
            acc_num_d = '0;
            acc_den_d = VALUE_WIDTH'(1);
          end
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        prod_d  = mul_p;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        num_d   = prod_q;
        prod_d  = mul_p;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        num_d   = num_q + prod_q;
        prod_d  = mul_p;
        state_d = S_MUL3;
      end
      S_MUL3: begin
        den_d   = prod_q;
        a_d     = num_q;
        b_d     = prod_q;
        state_d = S_GCD;
      end
      S_GCD: begin
        // a_q holds the gcd once b_q reaches zero
        priority if (b_q != '0) begin
          div_req.start = 1'b1;
          state_d       = S_REM;
        end else if (a_q == '0) begin
          status_d = STATUS_GCD_ZERO;
          state_d  = S_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = num_q;
          div_req.divisor  = a_q;
          state_d          = S_DIVN;
        end
      end
      S_REM: begin
        if (div_rsp.done) begin
          a_d     = b_q;
          b_d     = div_rsp.rem;
          state_d = S_GCD;
        end
      end
      S_DIVN: begin
        if (div_rsp.done) begin
          rn_d             = div_rsp.quot;
          div_req.start    = 1'b1;
          div_req.dividend = den_q;
          div_req.divisor  = a_q;
          state_d          = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_rsp.done) begin
          if (fits_value(rn_q) && fits_value(div_rsp.quot)) begin
            acc_num_d = rn_q[VALUE_WIDTH-1:0];
            acc_den_d = div_rsp.quot[VALUE_WIDTH-1:0];
            status_d  = STATUS_OK;
          end else begin
            status_d  = STATUS_OVERFLOW;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and the stored sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      status_q  <= STATUS_OK;
      acc_num_q <= '0;
      acc_den_q <= VALUE_WIDTH'(1);
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      acc_num_q <= acc_num_d;
      acc_den_q <= acc_den_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    n2_q   <= n2_d;
    d2_q   <= d2_d;
    prod_q <= prod_d;
    num_q  <= num_d;
    den_q  <= den_d;
    a_q    <= a_d;
    b_q    <= b_d;
    rn_q   <= rn_d;
  end

  // Drive the ports
  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = (state_q == S_OUT);
  assign sum_numerator_o   = FIELD_W'(acc_num_q);
  assign sum_denominator_o = FIELD_W'(acc_den_q);
  assign status_o          = status_q;

  // Checks
  a_busy_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result waits");

  a_accept_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_MUL0))
    else $error("accepted item did not start the multiply");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_REM || state_q == S_DIVN || state_q == S_DIVD))
    else $error("divider finished with no division pending");

  a_sum_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $past(out_valid_o)) |->
      ($stable(sum_numerator_o) && $stable(sum_denominator_o)))
    else $error("sum changed while the result waited");

endmodule

FILE: verif/rational_sum_accumulator_test.sv
// ----------------------------------------------------------------------------
// rational_sum_accumulator_test: self-checking bench for the fraction summer
// Offers fractions through the valid/stall input channel and predicts every
// reduced running sum with a behavioural model of cross-multiplication and
// Euclid reduction at 64 bits. Each result transfer is checked field by field
// against the oldest prediction. Directed extremes and corner cases come
// first, then a long receiver hold-off, then random fractions.
// ----------------------------------------------------------------------------
module rational_sum_accumulator_test;
  import rsa_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 10000;
  localparam int unsigned DRAIN_CYCLES = 8000;
  localparam int unsigned RANDOM_ITEMS = 75;

  typedef struct packed {
    logic signed [FIELD_W-1:0] num;
    logic signed [FIELD_W-1:0] den;
    status_e                   st;
  } sum_result_t;

  logic                      clk_i            = 1'b0;
  logic                      rst_ni           = 1'b0;
  logic                      in_valid_i       = 1'b0;
  logic                      in_stall_o;
  logic                      first_item_i     = 1'b0;
  logic signed [FIELD_W-1:0] in_numerator_i   = '0;
  logic signed [FIELD_W-1:0] in_denominator_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i      = 1'b1;
  logic signed [FIELD_W-1:0] sum_numerator_o;
  logic signed [FIELD_W-1:0] sum_denominator_o;
  logic [1:0]                status_o;

  // Model state: the stored sum, held sign-extended at 64 bits
  longint      model_num = 0;
  longint      model_den = 1;
  sum_result_t expected_sums[$];
  sum_result_t oldest_sum;
  int unsigned fail_count = 0;

  // Idling controls shared by the sender, the receiver and the tests
  bit          no_idle   = 1'b0;
  bit          hold_req  = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned gap_left  = 2;

  rational_sum_accumulator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .first_item_i     (first_item_i),
    .in_numerator_i   (in_numerator_i),
    .in_denominator_i (in_denominator_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sum_numerator_o  (sum_numerator_o),
    .sum_denominator_o(sum_denominator_o),
    .status_o         (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model --

  // Take the low VALUE_WIDTH bits of a field and sign-extend them to 64 bits
  function automatic longint sign_narrow(input logic [FIELD_W-1:0] raw);
    longint v;
    v = longint'($signed(raw));
    v = v <<< (64 - VALUE_WIDTH);
    return v >>> (64 - VALUE_WIDTH);
  endfunction

  // Truncating quotient; division by -1 is a wrapping negation
  function automatic longint trunc_quot(input longint a, input longint b);
    if (b == -1) return 64'sd0 - a;
    return a / b;
  endfunction

  // Add one fraction to the model sum and return the result it produces
  function automatic sum_result_t add_fraction(input logic first,
                                               input logic [FIELD_W-1:0] n_raw,
                                               input logic [FIELD_W-1:0] d_raw);
    longint      n2, d2, num, den, a, b, t, g, rn, rd, hi, lo;
    sum_result_t r;
    n2 = sign_narrow(n_raw);
    d2 = sign_narrow(d_raw);
    hi = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    r.st = STATUS_OK;
    if (first) begin
      model_num = 0;
      model_den = 1;
    end
    num = model_num * d2 + n2 * model_den;
    den = model_den * d2;
    // Euclid with truncating remainder; remainder by -1 is zero
    a = num;
    b = den;
    while (b != 0) begin
      t = b;
      b = (b == -1) ? 64'sd0 : a % b;
      a = t;
    end
    g = a;
    if (g == 0) begin
      r.st = STATUS_GCD_ZERO;
    end else begin
      rn = trunc_quot(num, g);
      rd = trunc_quot(den, g);
      if (rn >= lo && rn <= hi && rd >= lo && rd <= hi) begin
        model_num = rn;
        model_den = rd;
      end else begin
        r.st = STATUS_OVERFLOW;
      end
    end
    r.num = FIELD_W'(model_num);
    r.den = FIELD_W'(model_den);
    return r;
  endfunction

  // --------------------------------------------------------------- sender --

  // Offer one fraction after a random gap (none while no_idle is set) and predict it on transfer
  task automatic offer_fraction(input logic first, input logic [FIELD_W-1:0] n,
                                input logic [FIELD_W-1:0] d);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    first_item_i     = first;
    in_numerator_i   = n;
    in_denominator_i = d;
    do @(posedge clk_i); while (in_stall_o);
    expected_sums.push_back(add_fraction(first, n, d));
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every predicted sum has been checked
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (expected_sums.size() != 0) @(negedge clk_i);
  endtask

  // ------------------------------------------------------------- receiver --

  // Stall for a random gap before each result, or for a long counted hold
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        gap_left  = no_idle ? 0 : $urandom_range(0, 3);
        out_taken = 1'b0;
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left   = hold_left - 1;
        out_stall_i = 1'b1;
      end else if (gap_left > 0) begin
        gap_left    = gap_left - 1;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string field, input longint want,
                                 input longint got);
    fail_count = fail_count + 1;
    $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Check every result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_taken = 1'b1;
      if (expected_sums.size() == 0) begin
        fail_count = fail_count + 1;
        $display("%0t unexpected result: expected none, actual %0d/%0d status %0d",
                 $time, sum_numerator_o, sum_denominator_o, status_o);
      end else begin
        oldest_sum = expected_sums.pop_front();
        if (sum_numerator_o !== oldest_sum.num)
          report_mismatch("sum_numerator", oldest_sum.num, sum_numerator_o);
        if (sum_denominator_o !== oldest_sum.den)
          report_mismatch("sum_denominator", oldest_sum.den, sum_denominator_o);
        if (status_o !== oldest_sum.st)
          report_mismatch("status", oldest_sum.st, status_o);
      end
    end
  end

  // ---------------------------------------------------------------- tests --

  localparam logic [FIELD_W-1:0] MAX_V = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] MIN_V = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] ONES  = '1;

  // Extremes of the fields, alone and in combination
  task automatic test_extremes();
    offer_fraction(1'b0, 32'd1, 32'd2);
    offer_fraction(1'b0, 32'd1, 32'd3);
    offer_fraction(1'b1, MAX_V, MAX_V);
    offer_fraction(1'b0, MAX_V, 32'd1);
    offer_fraction(1'b1, MIN_V, MIN_V);
    offer_fraction(1'b1, MIN_V, MAX_V);
    offer_fraction(1'b0, MAX_V, MIN_V);
    offer_fraction(1'b1, ONES, ONES);
    offer_fraction(1'b1, 32'd0, MIN_V);
    offer_fraction(1'b0, ONES, MAX_V);
    wait_drained();
  endtask

  // Corner cases of the reduction and of the restart
  task automatic test_special_cases();
    // Negative gcd from two negative parts
    offer_fraction(1'b1, -32'sd7, -32'sd14);
    // Denominator of minus one
    offer_fraction(1'b0, 32'd3, ONES);
    // Restart that still takes effect when the add overflows
    offer_fraction(1'b1, MIN_V, ONES);
    // Zero over zero, with and without a restart
    offer_fraction(1'b0, 32'd5, 32'd6);
    offer_fraction(1'b0, 32'd0, 32'd0);
    offer_fraction(1'b1, 32'd0, 32'd0);
    // Zero denominators carried through the sum
    offer_fraction(1'b1, 32'd3, 32'd0);
    offer_fraction(1'b0, 32'd1, 32'd2);
    offer_fraction(1'b1, 32'd0, 32'd0);
    // Denominator product that leaves the stored range
    offer_fraction(1'b1, 32'd1, MAX_V);
    offer_fraction(1'b0, 32'd1, MAX_V - 32'd1);
    offer_fraction(1'b0, -32'sd4, 32'd5);
    wait_drained();
  endtask

  // Hold the receiver off while the sender keeps offering, so input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    no_idle  = 1'b1;
    offer_fraction(1'b1, 32'd2, 32'd9);
    offer_fraction(1'b0, -32'sd5, 32'd12);
    offer_fraction(1'b0, 32'd7, 32'd10);
    offer_fraction(1'b0, 32'd1, -32'sd3);
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Draw one random field value: mostly small, sometimes wide or extreme
  function automatic logic [FIELD_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return 32'd0;
      3:       return ($urandom_range(0, 1) != 0) ? MAX_V : MIN_V;
      4:       return $urandom_range(0, 65535) - 32'd32768;
      default: return $urandom_range(0, 60) - 32'd30;
    endcase
  endfunction

  // Random fractions with occasional restarts and a stretch with no idling
  task automatic test_random();
    logic first;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 40 && i < 60);
      first   = ($urandom_range(0, 7) == 0);
      offer_fraction(first, draw_value(), draw_value());
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Reset, run the tests in turn and give the verdict
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_special_cases();
    test_backpressure();
    test_random();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_sums.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run well beyond the slowest legal one
  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
